// ===== hdl/lcht_pkg.sv =====
package lcht_pkg;

  localparam int ABS_W    = 32;
  localparam int SPC_W    = 24;
  localparam int SPT_W    = 16;
  localparam int DRV_W    = 8;
  localparam int CYL_W    = 10;
  localparam int HEAD_W   = 8;
  localparam int WITHIN_W = SPC_W;

  // Head/sector divider: bits retired per stage and resulting stage count
  localparam int D2_STEPS  = 3;
  localparam int D2_STAGES = WITHIN_W / D2_STEPS;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_HIDDEN = 2'd0;
  localparam logic [1:0] REG_SPC    = 2'd1;
  localparam logic [1:0] REG_SPT    = 2'd2;
  localparam logic [1:0] REG_DRIVE  = 2'd3;

  localparam logic [HEAD_W-1:0] HEAD_MAX = '1;
  localparam logic [SPT_W-1:0]  SECT_MAX = '1;

  // Per-item data that rides along the divider pipelines
  typedef struct packed {
    logic             lba;
    logic [ABS_W-1:0] abs_sector;
    logic [CYL_W-1:0] cylinder;
  } lcht_side_t;

endpackage

// ===== hdl/lcht_cyl_div.sv =====
module lcht_cyl_div #(
  parameter int QW = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     src_valid,
  input  lcht_pkg::lcht_side_t     src_side,
  input  logic [lcht_pkg::SPC_W-1:0] spc,
  output logic                     dst_valid,
  output lcht_pkg::lcht_side_t     dst_side,
  output logic [QW-1:0]            quotient,
  output logic [lcht_pkg::SPC_W-1:0] remainder
);
  import lcht_pkg::*;

  localparam int BW = SPC_W + QW;
  localparam int DW = (BW > ABS_W) ? BW : ABS_W;

  logic [QW-1:0] v;
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] quo  [QW];
  lcht_side_t    side [QW];

  // One quotient bit per stage, most significant first; divisor shifted into place
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    lcht_side_t    side_in;
    logic [DW-1:0] dsh;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_in    = src_valid;
      assign rem_in  = DW'(src_side.abs_sector);
      assign quo_in  = '0;
      assign side_in = src_side;
    end else begin : g_next
      assign v_in    = v[j-1];
      assign rem_in  = rem[j-1];
      assign quo_in  = quo[j-1];
      assign side_in = side[j-1];
    end

    assign dsh = DW'(spc) << B;
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (advance) begin
        v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[j]  <= ge ? rem_in - dsh : rem_in;
        quo[j]  <= ge ? (quo_in | (QW'(1) << B)) : quo_in;
        side[j] <= side_in;
      end
    end
  end

  assign dst_valid = v[QW-1];
  assign dst_side  = side[QW-1];
  assign quotient  = quo[QW-1];
  assign remainder = rem[QW-1][SPC_W-1:0];

endmodule

// ===== hdl/lcht_head_div.sv =====
module lcht_head_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          src_valid,
  input  lcht_pkg::lcht_side_t          src_side,
  input  logic [lcht_pkg::WITHIN_W-1:0] src_within,
  input  logic [lcht_pkg::SPT_W-1:0]    spt,
  output logic                          dst_valid,
  output lcht_pkg::lcht_side_t          dst_side,
  output logic [lcht_pkg::WITHIN_W-1:0] dst_within,
  output logic [lcht_pkg::WITHIN_W-1:0] quotient,
  output logic [lcht_pkg::SPT_W-1:0]    remainder
);
  import lcht_pkg::*;

  logic [D2_STAGES-1:0] v;
  logic [SPT_W-1:0]     rem    [D2_STAGES];
  logic [WITHIN_W-1:0]  quo    [D2_STAGES];
  logic [WITHIN_W-1:0]  num    [D2_STAGES];
  logic [WITHIN_W-1:0]  dvd    [D2_STAGES];
  lcht_side_t           side   [D2_STAGES];

  // Shift-in restoring division, several narrow steps per stage
  for (genvar s = 0; s < D2_STAGES; s++) begin : g_stage
    logic                v_in;
    logic [SPT_W-1:0]    rem_in;
    logic [WITHIN_W-1:0] quo_in;
    logic [WITHIN_W-1:0] num_in;
    logic [WITHIN_W-1:0] dvd_in;
    lcht_side_t          side_in;
    logic [SPT_W-1:0]    rem_out;
    logic [WITHIN_W-1:0] quo_out;
    logic [WITHIN_W-1:0] num_out;

    if (s == 0) begin : g_first
      assign v_in    = src_valid;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = src_within;
      assign dvd_in  = src_within;
      assign side_in = src_side;
    end else begin : g_next
      assign v_in    = v[s-1];
      assign rem_in  = rem[s-1];
      assign quo_in  = quo[s-1];
      assign num_in  = num[s-1];
      assign dvd_in  = dvd[s-1];
      assign side_in = side[s-1];
    end

    always_comb begin
      logic [SPT_W:0] trial;
      logic           ge;
      rem_out = rem_in;
      quo_out = quo_in;
      num_out = num_in;
      for (int t = 0; t < D2_STEPS; t++) begin
        trial   = {rem_out, num_out[WITHIN_W-1]};
        num_out = num_out << 1;
        ge      = trial >= {1'b0, spt};
        rem_out = ge ? SPT_W'(trial - {1'b0, spt}) : SPT_W'(trial);
        quo_out = {quo_out[WITHIN_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (advance) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[s]  <= rem_out;
        quo[s]  <= quo_out;
        num[s]  <= num_out;
        dvd[s]  <= dvd_in;
        side[s] <= side_in;
      end
    end
  end

  assign dst_valid  = v[D2_STAGES-1];
  assign dst_side   = side[D2_STAGES-1];
  assign dst_within = dvd[D2_STAGES-1];
  assign quotient   = quo[D2_STAGES-1];
  assign remainder  = rem[D2_STAGES-1];

endmodule

// ===== hdl/lba_to_chs_translator.sv =====
// LBA to CHS translator. Each transfer on the req channel carries a
// partition-relative logical sector; the block adds the hidden-sector offset
// (mod 2^32) and returns one transfer on the rsp channel with the absolute
// sector, the drive number and either a CHS triple or use_lba set when the
// cylinder reaches CYLINDER_LIMIT (cylinder, head and sector are then zero).
// A head above 255 saturates, and so does a sector above 65535. Rate is one
// item per cycle while the pipeline advances. A request passes through the
// offset stage, which captures at the transfer, then the limit compare stage,
// one cylinder quotient bit per stage in the first divider, eight stages of
// three head quotient bits in the second, and the output register. The
// pipeline advances as a whole: it holds only while a result waits with
// rsp_stall high.
// Registers sit on an APB port at 4*index: hidden-sector offset, sectors per
// cylinder, sectors per track, drive number; write them only while no item is
// in flight.
module lba_to_chs_translator #(
  parameter int CYLINDER_LIMIT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcht_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcht_pkg::DATA_W-1:0]   pwdata,
  output logic [lcht_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [lcht_pkg::ABS_W-1:0]    logical_sector,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          use_lba,
  output logic [lcht_pkg::ABS_W-1:0]    absolute_sector,
  output logic [lcht_pkg::CYL_W-1:0]    cylinder,
  output logic [lcht_pkg::HEAD_W-1:0]   head_number,
  output logic [lcht_pkg::SPT_W-1:0]    sector_in_track,
  output logic [lcht_pkg::DRV_W-1:0]    drive
);
  import lcht_pkg::*;

  localparam int QW = $clog2(CYLINDER_LIMIT);
  localparam int BW = SPC_W + QW;
  localparam int CW = (BW > ABS_W) ? BW : ABS_W;

  // Configuration registers
  logic [ABS_W-1:0] hidden_sectors;
  logic [SPC_W-1:0] cyl_sectors;
  logic [SPT_W-1:0] trk_sectors;
  logic [DRV_W-1:0] drive_number;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hidden_sectors <= '0;
      cyl_sectors    <= SPC_W'(1);
      trk_sectors    <= SPT_W'(1);
      drive_number   <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_HIDDEN: hidden_sectors <= pwdata[ABS_W-1:0];
        REG_SPC:    cyl_sectors    <= pwdata[SPC_W-1:0];
        REG_SPT:    trk_sectors    <= pwdata[SPT_W-1:0];
        REG_DRIVE:  drive_number   <= pwdata[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HIDDEN: prdata = DATA_W'(hidden_sectors);
      REG_SPC:    prdata = DATA_W'(cyl_sectors);
      REG_SPT:    prdata = DATA_W'(trk_sectors);
      REG_DRIVE:  prdata = DATA_W'(drive_number);
      default:    prdata = '0;
    endcase
  end

  // Whole-pipeline enable: hold everything only while a result waits
  logic advance;

  assign advance   = !(rsp_valid && rsp_stall);
  assign req_stall = !advance;

  // Cylinder bound: cyl_sectors * CYLINDER_LIMIT, registered, so it follows
  // the register in the next cycle. With zero sectors per cylinder the
  // bound is zero, so every item goes to LBA as a zero divisor demands.
  logic [BW-1:0] cyl_bound;

  always_ff @(posedge clk) begin
    cyl_bound <= BW'(cyl_sectors) * BW'(CYLINDER_LIMIT);
  end

  // Stage 0: absolute sector
  logic             s0_valid;
  logic [ABS_W-1:0] s0_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_abs <= logical_sector + hidden_sectors;
    end
  end

  // Stage 1: decide LBA against the bound; a CHS item then has a quotient
  // that fits in QW bits, which the cylinder divider relies on
  logic       s1_valid;
  lcht_side_t s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_side.lba        <= CW'(s0_abs) >= CW'(cyl_bound);
      s1_side.abs_sector <= s0_abs;
      s1_side.cylinder   <= '0;
    end
  end

  // Cylinder divider: absolute sector / sectors per cylinder
  logic             d1_valid;
  lcht_side_t       d1_side;
  logic [QW-1:0]    d1_quo;
  logic [SPC_W-1:0] d1_rem;

  lcht_cyl_div #(
    .QW (QW)
  ) u_cyl_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .src_valid (s1_valid),
    .src_side  (s1_side),
    .spc       (cyl_sectors),
    .dst_valid (d1_valid),
    .dst_side  (d1_side),
    .quotient  (d1_quo),
    .remainder (d1_rem)
  );

  // Keep the low cylinder bits only; zero-extend a narrow quotient
  logic [QW+CYL_W-1:0] d1_quo_ext;
  lcht_side_t          d2_src_side;

  assign d1_quo_ext = (QW + CYL_W)'(d1_quo);

  always_comb begin
    d2_src_side          = d1_side;
    d2_src_side.cylinder = d1_quo_ext[CYL_W-1:0];
  end

  // Head divider: remainder / sectors per track
  logic                d2_valid;
  lcht_side_t          d2_side;
  logic [WITHIN_W-1:0] d2_within;
  logic [WITHIN_W-1:0] d2_quo;
  logic [SPT_W-1:0]    d2_rem;

  lcht_head_div u_head_div (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .src_valid  (d1_valid),
    .src_side   (d2_src_side),
    .src_within (d1_rem),
    .spt        (trk_sectors),
    .dst_valid  (d2_valid),
    .dst_side   (d2_side),
    .dst_within (d2_within),
    .quotient   (d2_quo),
    .remainder  (d2_rem)
  );

  // Final stage: saturate, apply the zero-divisor case, blank CHS for LBA
  logic [HEAD_W-1:0] head_sat;
  logic [SPT_W-1:0]  sect_sat;

  always_comb begin
    // zero sectors per track gives an all-ones quotient, so the head saturates
    head_sat = (|d2_quo[WITHIN_W-1:HEAD_W]) ? HEAD_MAX : d2_quo[HEAD_W-1:0];
    if (trk_sectors == '0) begin
      // remainder is the whole dividend; plus one, clipped to 16 bits
      sect_sat = (d2_within >= WITHIN_W'(SECT_MAX)) ? SECT_MAX
                                                    : SPT_W'(d2_within + WITHIN_W'(1));
    end else begin
      sect_sat = d2_rem + SPT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      use_lba         <= d2_side.lba;
      absolute_sector <= d2_side.abs_sector;
      cylinder        <= d2_side.lba ? '0 : d2_side.cylinder;
      head_number     <= d2_side.lba ? '0 : head_sat;
      sector_in_track <= d2_side.lba ? '0 : sect_sat;
      drive           <= drive_number;
    end
  end

  // A CHS result always carries a one-based sector
  a_sector_nonzero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !use_lba |-> sector_in_track != '0)
    else $error("CHS result with sector zero");

  // An item in the first stage moves on whenever the pipeline advances
  a_stage_moves : assert property (@(posedge clk) disable iff (rst)
    s0_valid && advance |=> s1_valid)
    else $error("item lost between stage 0 and stage 1");

  // A held pipeline keeps its stage occupancy
  a_hold_keeps : assert property (@(posedge clk) disable iff (rst)
    !advance |=> s0_valid == $past(s0_valid) && d2_valid == $past(d2_valid))
    else $error("stage occupancy changed while held");

endmodule

// ===== tb/lcht_checker.sv =====
`timescale 1ns / 100ps

module lcht_checker #(
  parameter int CYLINDER_LIMIT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcht_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcht_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [lcht_pkg::ABS_W-1:0]    logical_sector,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic                          use_lba,
  input  logic [lcht_pkg::ABS_W-1:0]    absolute_sector,
  input  logic [lcht_pkg::CYL_W-1:0]    cylinder,
  input  logic [lcht_pkg::HEAD_W-1:0]   head_number,
  input  logic [lcht_pkg::SPT_W-1:0]    sector_in_track,
  input  logic [lcht_pkg::DRV_W-1:0]    drive,
  output int                            fail_count,
  output int                            pending
);
  import lcht_pkg::*;

  typedef struct packed {
    logic              lba;
    logic [ABS_W-1:0]  abs_sector;
    logic [CYL_W-1:0]  cyl;
    logic [HEAD_W-1:0] head;
    logic [SPT_W-1:0]  sect;
    logic [DRV_W-1:0]  drv;
  } chs_addr_t;

  logic [ABS_W-1:0] geo_hidden;
  logic [SPC_W-1:0] geo_spc;
  logic [SPT_W-1:0] geo_spt;
  logic [DRV_W-1:0] geo_drive;

  chs_addr_t translated_q[$];

  function automatic chs_addr_t translate_sector(input logic [ABS_W-1:0] lsec);
    logic [31:0] abs_s;
    logic [31:0] cyl_q;
    logic [31:0] cyl_rem;
    logic [31:0] head_q;
    logic [31:0] srem;
    logic [32:0] sect;
    chs_addr_t r;
    abs_s = lsec + geo_hidden;
    // a zero divisor gives an all-ones quotient and keeps the dividend
    if (geo_spc == '0) begin
      cyl_q   = '1;
      cyl_rem = abs_s;
    end else begin
      cyl_q   = abs_s / geo_spc;
      cyl_rem = abs_s % geo_spc;
    end
    if (geo_spt == '0) begin
      head_q = '1;
      srem   = cyl_rem;
    end else begin
      head_q = cyl_rem / geo_spt;
      srem   = cyl_rem % geo_spt;
    end
    r.abs_sector = abs_s;
    r.drv        = geo_drive;
    if (longint'(cyl_q) >= longint'(CYLINDER_LIMIT)) begin
      r.lba  = 1'b1;
      r.cyl  = '0;
      r.head = '0;
      r.sect = '0;
    end else begin
      sect   = {1'b0, srem} + 33'd1;
      r.lba  = 1'b0;
      r.cyl  = cyl_q[CYL_W-1:0];
      r.head = (head_q > 32'(HEAD_MAX)) ? HEAD_MAX : head_q[HEAD_W-1:0];
      r.sect = (sect > 33'(SECT_MAX)) ? SECT_MAX : sect[SPT_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    chs_addr_t want;
    if (rst) begin
      geo_hidden = '0;
      geo_spc    = SPC_W'(1);
      geo_spt    = SPT_W'(1);
      geo_drive  = '0;
      fail_count = 0;
      translated_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (translated_q.size() == 0) begin
          report_mismatch("result with nothing pending, absolute_sector",
                          absolute_sector, '0);
        end else begin
          want = translated_q.pop_front();
          if (use_lba !== want.lba)
            report_mismatch("use_lba", 32'(use_lba), 32'(want.lba));
          if (absolute_sector !== want.abs_sector)
            report_mismatch("absolute_sector", absolute_sector, want.abs_sector);
          if (cylinder !== want.cyl)
            report_mismatch("cylinder", 32'(cylinder), 32'(want.cyl));
          if (head_number !== want.head)
            report_mismatch("head_number", 32'(head_number), 32'(want.head));
          if (sector_in_track !== want.sect)
            report_mismatch("sector_in_track", 32'(sector_in_track), 32'(want.sect));
          if (drive !== want.drv)
            report_mismatch("drive", 32'(drive), 32'(want.drv));
        end
      end
      if (req_valid && !req_stall)
        translated_q.push_back(translate_sector(logical_sector));
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_HIDDEN: geo_hidden = pwdata[ABS_W-1:0];
          REG_SPC:    geo_spc    = pwdata[SPC_W-1:0];
          REG_SPT:    geo_spt    = pwdata[SPT_W-1:0];
          REG_DRIVE:  geo_drive  = pwdata[DRV_W-1:0];
          default: ;
        endcase
      end
    end
    pending = translated_q.size();
  end

endmodule

// ===== tb/tb_lba_to_chs_translator.sv =====
`timescale 1ns / 100ps

module tb_lba_to_chs_translator;
  import lcht_pkg::*;

  localparam int CYLINDER_LIMIT  = 1024;
  // pipeline depth: offset, compare, one per quotient bit, head stages, output
  localparam int LATENCY         = $clog2(CYLINDER_LIMIT) + 11;
  localparam int IDLE_LIMIT      = 2000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 100;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                req_valid      = 1'b0;
  logic                req_stall;
  logic [ABS_W-1:0]    logical_sector = '0;
  logic                rsp_valid;
  logic                rsp_stall      = 1'b0;
  logic                use_lba;
  logic [ABS_W-1:0]    absolute_sector;
  logic [CYL_W-1:0]    cylinder;
  logic [HEAD_W-1:0]   head_number;
  logic [SPT_W-1:0]    sector_in_track;
  logic [DRV_W-1:0]    drive;

  int fail_count;
  int pending;

  // quiet mode: no gaps on the request side, no stalls on the response side
  bit calm = 1'b0;

  // geometry currently programmed, used only to aim the random sectors
  logic [ABS_W-1:0] cur_hidden = '0;
  logic [SPC_W-1:0] cur_spc    = 1;

  lba_to_chs_translator #(
    .CYLINDER_LIMIT(CYLINDER_LIMIT)
  ) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .logical_sector(logical_sector),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .use_lba(use_lba),
    .absolute_sector(absolute_sector), .cylinder(cylinder),
    .head_number(head_number), .sector_in_track(sector_in_track), .drive(drive)
  );

  lcht_checker #(
    .CYLINDER_LIMIT(CYLINDER_LIMIT)
  ) scoreboard (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .logical_sector(logical_sector),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .use_lba(use_lba),
    .absolute_sector(absolute_sector), .cylinder(cylinder),
    .head_number(head_number), .sector_in_track(sector_in_track), .drive(drive),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // Response-side backpressure: stall in bursts of random length, drop it in quiet mode.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(5, 0) == 0) begin
      stall_left = $urandom_range(5, 1) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles in which no transfer and no register access happens.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Write one register: setup cycle, then access cycle until pready.
  // Call at a falling edge; return at a falling edge.
  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid and hold off until every translated address has come back,
  // then let the pipeline settle.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic set_geometry(input logic [DATA_W-1:0] hidden, input logic [DATA_W-1:0] spc,
                              input logic [DATA_W-1:0] spt, input logic [DATA_W-1:0] drv);
    wait_drained();
    apb_write(REG_HIDDEN, hidden);
    apb_write(REG_SPC, spc);
    apb_write(REG_SPT, spt);
    apb_write(REG_DRIVE, drv);
    cur_hidden = hidden[ABS_W-1:0];
    cur_spc    = spc[SPC_W-1:0];
  endtask

  // One request transfer, with an optional gap first. Valid stays high after
  // acceptance so back-to-back transfers need no extra edge on it.
  task automatic send_sector(input logic [ABS_W-1:0] lsec);
    if (!calm && $urandom_range(3, 0) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
    req_valid      <= 1'b1;
    logical_sector <= lsec;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin
    int               ph;
    int               n;
    int               mode;
    longint           spc_eff;
    longint           span;
    longint           target;
    logic [DATA_W-1:0] g_hid;
    logic [DATA_W-1:0] g_spc;
    logic [DATA_W-1:0] g_spt;
    logic [DATA_W-1:0] g_drv;
    int               heads;

    // hold reset at the start, release at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: one sector per cylinder, so the cylinder is the sector itself.
    send_sector(32'd0);
    send_sector(32'd1023);
    send_sector(32'd1024);
    send_sector(32'hFFFF_FFFF);

    // Classic 255-head, 63-sector geometry; hit both sides of the CHS limit
    // and wrap the offset addition back to zero.
    set_geometry(32'd63, 32'd16065, 32'd63, 32'h80);
    send_sector(32'd0);
    send_sector(32'd62);
    send_sector(32'd63);
    send_sector(32'd16064);
    send_sector(32'(1023 * 16065 + 16064 - 63));
    send_sector(32'(1024 * 16065 - 63));
    send_sector(32'hFFFF_FFC1);

    // Zero sectors per cylinder: the cylinder bound is zero, so LBA is forced.
    set_geometry(32'hFFFF_FFFF, 32'd0, 32'd5, 32'hFF);
    send_sector(32'd1);
    send_sector(32'd0);

    // Zero sectors per track: the head saturates, and so does a sector above 65535.
    set_geometry(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h55);
    send_sector(32'd100);
    send_sector(32'd70000);
    send_sector(32'd16777214);

    // Cylinder larger than 256 tracks: a head above 255 saturates at 255.
    set_geometry(32'd0, 32'd1000, 32'd1, 32'h01);
    send_sector(32'd999);
    send_sector(32'd300);
    send_sector(32'd200);

    // Random phases, each with its own geometry; the last one runs quiet.
    for (ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(5, 0))
        0, 1, 2: begin
          g_spt = $urandom_range(63, 1);
          heads = $urandom_range(255, 1);
          g_spc = g_spt * heads;
          g_hid = $urandom_range(2047, 0);
          g_drv = $urandom;
        end
        3: begin
          g_spt = $urandom_range(65535, 1);
          heads = $urandom_range(255, 1);
          g_spc = g_spt * heads;
          g_hid = $urandom;
          g_drv = $urandom;
        end
        4: begin
          // raw words: upper bits must be dropped by the register widths
          g_hid = $urandom;
          g_spc = $urandom;
          g_spt = $urandom;
          g_drv = $urandom;
        end
        default: begin
          case ($urandom_range(3, 0))
            0: g_spc = 32'd0;
            1: g_spc = 32'd1;
            2: g_spc = 32'h00FF_FFFF;
            default: g_spc = 32'd16711425;
          endcase
          case ($urandom_range(2, 0))
            0: g_spt = 32'd0;
            1: g_spt = 32'd1;
            default: g_spt = 32'h0000_FFFF;
          endcase
          g_hid = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'd0;
          g_drv = $urandom_range(1, 0) ? 32'hFF : 32'd0;
        end
      endcase
      set_geometry(g_hid, g_spc, g_spt, g_drv);
      calm = (ph == PHASES - 1);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // now and then hold off until the pipeline has emptied
        if (!calm && $urandom_range(149, 0) == 0) wait_drained();
        mode    = $urandom_range(9, 0);
        spc_eff = (cur_spc == '0) ? 64'd1 : longint'(cur_spc);
        if (mode < 7) begin
          // aim mostly inside the CHS range, with some overshoot into LBA
          span = spc_eff * 1100;
          if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
          target = $urandom_range(32'(span), 0);
          send_sector(32'(target) - cur_hidden);
        end else if (mode == 7) begin
          // straddle the first cylinder past the limit
          target = spc_eff * CYLINDER_LIMIT - 4 + $urandom_range(8, 0);
          send_sector(32'(target) - cur_hidden);
        end else begin
          send_sector($urandom);
        end
      end
    end

    // Drain: wait for every result, then idle past the pipeline depth.
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
